// ===== src/ufm_pkg.sv =====
// Shared types, constants and the classifier function for the UTF-8 final byte marker.
// Holds the per-byte class record and the classifier used by the history chain.
// No dependencies.
package ufm_pkg;

    localparam int unsigned HIST_DEPTH = 3;
    localparam int unsigned BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
    localparam logic [BYTE_W-1:0] BYTE_E0  = 8'hE0;
    localparam logic [BYTE_W-1:0] BYTE_ED  = 8'hED;
    localparam logic [BYTE_W-1:0] BYTE_F0  = 8'hF0;
    localparam logic [BYTE_W-1:0] BYTE_F4  = 8'hF4;

    typedef struct packed {
        logic lead2;
        logic lead3;
        logic lead4;
        logic is_e0;
        logic is_ed;
        logic is_f0;
        logic is_f4;
    } byte_class_t;

    function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
        byte_class_t k;
        k.lead2 = (b >= LEAD2_LO) && (b <= LEAD2_HI);
        k.lead3 = (b >= LEAD3_LO) && (b <= LEAD3_HI);
        k.lead4 = (b >= LEAD4_LO) && (b <= LEAD4_HI);
        k.is_e0 = (b == BYTE_E0);
        k.is_ed = (b == BYTE_ED);
        k.is_f0 = (b == BYTE_F0);
        k.is_f4 = (b == BYTE_F4);
        return k;
    endfunction

endpackage

// ===== src/ufm_cell.sv =====
// One history cell of the UTF-8 final byte marker chain.
// Holds the class record of one past byte and passes it on each beat.
// Depends on ufm_pkg.
module ufm_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  ufm_pkg::byte_class_t class_in,
    output ufm_pkg::byte_class_t class_out
);

    ufm_pkg::byte_class_t class_reg;
    ufm_pkg::byte_class_t class_next;

    always_comb
    begin
        class_next = shift ? class_in : class_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= '0;
        end
        else
        begin
            class_reg <= class_next;
        end
    end

    assign class_out = class_reg;

endmodule

// ===== src/ufm_out.sv =====
// Output register stage of the UTF-8 final byte marker.
// Holds one result beat and lets a new input beat in while it drains.
// Depends on nothing outside this file.
module ufm_out
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       flag_in,
    output logic       can_load,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic valid_reg;
    logic valid_next;
    logic flag_reg;
    logic flag_next;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        flag_next  = flag_reg;
        if (load)
        begin
            valid_next = 1'b1;
            flag_next  = flag_in;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, flag_reg};

endmodule

// ===== src/utf8_final_byte_marker.sv =====
// Top level of the UTF-8 final byte marker.
// Judges each byte against a chain of three history cells; uses ufm_pkg, ufm_cell, ufm_out.
//
//   Channel  Dir  Payload (low bit up)       Width
//   s_*      in   data_byte                  8
//   m_*      out  is_final, zero pad         8
//
// One byte is taken every cycle while the output register can load; its flag appears in the cycle after the input beat.
// The judgement is one level of compare logic on the byte and the three history cells.
// Reset clears the history to zero bytes and empties the output register.
// A stalled output register holds its beat; the input is taken as soon as it drains.
module utf8_final_byte_marker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_final, [7:1] zero
);

    localparam int unsigned DEPTH = ufm_pkg::HIST_DEPTH;

    ufm_pkg::byte_class_t hist [DEPTH+1];
    ufm_pkg::byte_class_t cur;
    logic accept;
    logic can_load;
    logic is_lead;
    logic is_cont;
    logic legal_lead;
    logic slot_open;
    logic non_final;
    logic excluded;
    logic invalid;
    logic is_final;

    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;
    assign cur      = ufm_pkg::classify(s_tdata);
    assign hist[0]  = cur;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ufm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (accept),
            .class_in  (hist[i]),
            .class_out (hist[i+1])
        );
    end

    always_comb
    begin
        is_lead    = (s_tdata[7:6] == 2'b11);
        is_cont    = (s_tdata[7:6] == 2'b10);
        legal_lead = cur.lead2 || cur.lead3 || cur.lead4;
        slot_open  = hist[1].lead2 || hist[1].lead3 || hist[2].lead3 ||
                     hist[1].lead4 || hist[2].lead4 || hist[3].lead4;
        non_final  = is_lead || hist[1].lead3 || hist[1].lead4 || hist[2].lead4;
        excluded   = (hist[1].is_e0 && (s_tdata[7:5] == 3'b100)) ||
                     (hist[1].is_ed && (s_tdata[7:5] == 3'b101)) ||
                     (hist[1].is_f0 && (s_tdata[7:4] == 4'b1000)) ||
                     (hist[1].is_f4 && is_cont && (s_tdata[7:4] != 4'b1000));
        invalid    = (is_lead != legal_lead) || (slot_open != is_cont) || excluded;
        is_final   = !(non_final && !invalid);
    end

    ufm_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .flag_in  (is_final),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted byte produced no output beat");

    a_ascii_final: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tdata[7] |=> m_tdata[0])
        else $error("ASCII byte not flagged final");

    a_bad_lead_final: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_tdata[7:1] == 7'b1100000) |=> m_tdata[0])
        else $error("C0/C1 lead not flagged final");

    a_legal_lead_open: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cur.lead2 && !slot_open |=> !m_tdata[0])
        else $error("legal lead with no open slot flagged final");

endmodule
